// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the indexed priority table unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== hw/rtl/ipt_pkg.sv =====
// types and constants of the indexed priority table
`default_nettype none

package ipt_pkg;

    // default sizing of the table
    localparam int IPT_CAPACITY     = 256;
    localparam int IPT_RANK_WIDTH   = 16;
    localparam int IPT_OBJECT_WIDTH = 32;

    // fixed port field widths
    localparam int KIND_W      = 3;
    localparam int ID_W        = 8;
    localparam int OBJ_PORT_W  = 32;
    localparam int RANK_PORT_W = 16;
    localparam int STATUS_W    = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD     = 3'd0,
        KIND_PROMOTE = 3'd1,
        KIND_POP     = 3'd2,
        KIND_PEEK    = 3'd3,
        KIND_QUERY   = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_DEAD  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_LOOK,
        S_SCAN,
        S_FINISH,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/ipt_ram.sv =====
// generic single clock ram, one write and one registered read port
`default_nettype none

module ipt_ram #(
    parameter int WIDTH = 1 + ipt_pkg::IPT_RANK_WIDTH + ipt_pkg::IPT_OBJECT_WIDTH,
    parameter int DEPTH = ipt_pkg::IPT_CAPACITY
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/indexed_priority_table_unit.sv =====
// indexed priority table: id-addressed ranked entries with max search
`default_nettype none
//
// Usage
// - input channel i_in_valid / o_in_stall carries one item: i_kind
//   (add, promote, pop max, peek max, query), i_entry_id, i_object_value
// - output channel o_out_valid / i_out_stall returns exactly one result item
//   per input item, in order: status, id, object, rank, live flag
// - one item is worked on at a time; o_in_stall is high from the cycle after
//   acceptance until its result has moved into the output register
// - work per kind: add, kind codes without meaning, an unknown id and an
//   empty table finish in the issue state; promote and query do one ram
//   read, and promote also one ram write back; pop max and peek max scan
//   all next_id entries, with next_id the count of ids handed out; the
//   scan reads one entry per cycle through the single ram read port
// - entries live in one ram word {live, rank, object}; the live bit of an
//   id at or above next_id is never used, so no clearing pass is needed
// - a result waiting in the output register does not block the next item;
//   if the receiver stalls, the following result waits in its own register
//   and o_in_stall stays high until the output register frees up
// - reset (synchronous, active low) empties the table and the output
//
`include "assert_macros.svh"

module indexed_priority_table_unit #(
    parameter int CAPACITY     = ipt_pkg::IPT_CAPACITY,
    parameter int RANK_WIDTH   = ipt_pkg::IPT_RANK_WIDTH,
    parameter int OBJECT_WIDTH = ipt_pkg::IPT_OBJECT_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [ipt_pkg::KIND_W-1:0]      i_kind,
    input  wire logic [ipt_pkg::ID_W-1:0]        i_entry_id,
    input  wire logic [ipt_pkg::OBJ_PORT_W-1:0]  i_object_value,
    // output channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [ipt_pkg::STATUS_W-1:0]         o_status,
    output logic [ipt_pkg::ID_W-1:0]             o_result_id,
    output logic [ipt_pkg::OBJ_PORT_W-1:0]       o_result_object,
    output logic [ipt_pkg::RANK_PORT_W-1:0]      o_result_rank,
    output logic                                 o_is_live
);

    import ipt_pkg::*;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WORD_W = 1 + RANK_WIDTH + OBJECT_WIDTH;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // control state
    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_next_id, n_next_id;
    logic                     r_out_valid, n_out_valid;

    // latched item
    logic [KIND_W-1:0]        r_kind, n_kind;
    logic [ID_W-1:0]          r_id, n_id;
    logic [OBJECT_WIDTH-1:0]  r_obj, n_obj;

    // scan state
    logic [IDX_W-1:0]         r_scan_idx, n_scan_idx;
    logic                     r_found, n_found;
    logic [IDX_W-1:0]         r_best_idx, n_best_idx;
    logic [RANK_WIDTH-1:0]    r_best_rank, n_best_rank;
    logic [OBJECT_WIDTH-1:0]  r_best_obj, n_best_obj;

    // finished result, waiting for the output register
    logic [STATUS_W-1:0]      r_res_status, n_res_status;
    logic [ID_W-1:0]          r_res_id, n_res_id;
    logic [OBJ_PORT_W-1:0]    r_res_obj, n_res_obj;
    logic [RANK_PORT_W-1:0]   r_res_rank, n_res_rank;
    logic                     r_res_live, n_res_live;

    // output register
    logic [STATUS_W-1:0]      r_out_status, n_out_status;
    logic [ID_W-1:0]          r_out_id, n_out_id;
    logic [OBJ_PORT_W-1:0]    r_out_obj, n_out_obj;
    logic [RANK_PORT_W-1:0]   r_out_rank, n_out_rank;
    logic                     r_out_live, n_out_live;

    // ram port
    logic                     ram_wr_en;
    logic [IDX_W-1:0]         ram_wr_addr;
    logic [WORD_W-1:0]        ram_wr_data;
    logic                     ram_rd_en;
    logic [IDX_W-1:0]         ram_rd_addr;
    logic [WORD_W-1:0]        ram_rd_data;

    // decoded ram word and width adapted views
    logic                     rd_live;
    logic [RANK_WIDTH-1:0]    rd_rank;
    logic [OBJECT_WIDTH-1:0]  rd_obj;
    logic [RANK_WIDTH-1:0]    new_rank;
    logic [31:0]              rd_rank_w, new_rank_w, best_rank_w;
    logic [63:0]              rd_obj_w, best_obj_w, in_obj_w;
    logic [31:0]              id_w, next_id_w, best_idx_w, scan_idx_w;
    logic [IDX_W-1:0]         id_addr;
    logic                     id_known;
    logic                     table_full;
    logic                     scan_last;
    logic                     out_free;

    ipt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign rd_live  = ram_rd_data[WORD_W-1];
    assign rd_rank  = ram_rd_data[OBJECT_WIDTH +: RANK_WIDTH];
    assign rd_obj   = ram_rd_data[OBJECT_WIDTH-1:0];

    // promote saturates at the all ones rank
    assign new_rank = (rd_rank == '1) ? rd_rank : rd_rank + RANK_WIDTH'(1);

    assign rd_rank_w   = 32'(rd_rank);
    assign new_rank_w  = 32'(new_rank);
    assign best_rank_w = 32'(r_best_rank);
    assign rd_obj_w    = 64'(rd_obj);
    assign best_obj_w  = 64'(r_best_obj);
    assign in_obj_w    = 64'(i_object_value);
    assign id_w        = 32'(r_id);
    assign next_id_w   = 32'(r_next_id);
    assign best_idx_w  = 32'(r_best_idx);
    assign scan_idx_w  = 32'(r_scan_idx);

    assign id_addr    = id_w[IDX_W-1:0];
    // ids at or above next_id were never handed out
    assign id_known   = id_w < next_id_w;
    assign table_full = (r_next_id == CAP_CNT);
    assign scan_last  = (scan_idx_w == next_id_w - 32'd1);
    assign out_free   = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                case (r_kind)
                    KIND_PROMOTE, KIND_QUERY: begin
                        n_state = id_known ? S_LOOK : S_DONE;
                    end
                    KIND_POP, KIND_PEEK: begin
                        n_state = (r_next_id == '0) ? S_DONE : S_SCAN;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_LOOK: begin
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath, ram control and result
    always_comb begin
        n_next_id    = r_next_id;
        n_kind       = r_kind;
        n_id         = r_id;
        n_obj        = r_obj;
        n_scan_idx   = r_scan_idx;
        n_found      = r_found;
        n_best_idx   = r_best_idx;
        n_best_rank  = r_best_rank;
        n_best_obj   = r_best_obj;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_obj    = r_res_obj;
        n_res_rank   = r_res_rank;
        n_res_live   = r_res_live;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_obj    = r_out_obj;
        n_out_rank   = r_out_rank;
        n_out_live   = r_out_live;
        // output item leaves when the receiver does not stall
        n_out_valid  = r_out_valid && i_out_stall;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = '0;
        ram_wr_data  = '0;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind = i_kind;
                    n_id   = i_entry_id;
                    n_obj  = in_obj_w[OBJECT_WIDTH-1:0];
                end
            end
            S_ISSUE: begin
                n_res_status = STAT_OK;
                n_res_id     = '0;
                n_res_obj    = '0;
                n_res_rank   = '0;
                n_res_live   = 1'b0;
                case (r_kind)
                    KIND_ADD: begin
                        if (table_full) begin
                            n_res_status = STAT_FULL;
                        end else begin
                            // new entry: live, rank zero
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = next_id_w[IDX_W-1:0];
                            ram_wr_data = {1'b1, RANK_WIDTH'(0), r_obj};
                            n_res_id    = next_id_w[ID_W-1:0];
                            n_next_id   = r_next_id + CNT_W'(1);
                        end
                    end
                    KIND_PROMOTE, KIND_QUERY: begin
                        n_res_id = r_id;
                        if (id_known) begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = id_addr;
                        end else begin
                            n_res_status = STAT_DEAD;
                        end
                    end
                    KIND_POP, KIND_PEEK: begin
                        if (r_next_id == '0) begin
                            n_res_status = STAT_EMPTY;
                        end else begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = '0;
                            n_scan_idx  = '0;
                            n_found     = 1'b0;
                        end
                    end
                    default: begin
                        n_res_status = STAT_OK;
                    end
                endcase
            end
            S_LOOK: begin
                if (rd_live) begin
                    n_res_status = STAT_OK;
                    n_res_obj    = rd_obj_w[OBJ_PORT_W-1:0];
                    n_res_live   = 1'b1;
                    if (r_kind == KIND_PROMOTE) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = id_addr;
                        ram_wr_data = {1'b1, new_rank, rd_obj};
                        n_res_rank  = new_rank_w[RANK_PORT_W-1:0];
                    end else begin
                        n_res_rank  = rd_rank_w[RANK_PORT_W-1:0];
                    end
                end else begin
                    // popped entry: query still shows the stored object
                    n_res_status = STAT_DEAD;
                    n_res_rank   = '0;
                    n_res_live   = 1'b0;
                    n_res_obj    = (r_kind == KIND_QUERY) ? rd_obj_w[OBJ_PORT_W-1:0] : '0;
                end
            end
            S_SCAN: begin
                // data of r_scan_idx arrives, fetch the following entry
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_scan_idx + IDX_W'(1);
                n_scan_idx  = r_scan_idx + IDX_W'(1);
                // ties go to the later, larger id
                if (rd_live && (!r_found || rd_rank >= r_best_rank)) begin
                    n_found     = 1'b1;
                    n_best_idx  = r_scan_idx;
                    n_best_rank = rd_rank;
                    n_best_obj  = rd_obj;
                end
            end
            S_FINISH: begin
                if (r_found) begin
                    n_res_status = STAT_OK;
                    n_res_id     = best_idx_w[ID_W-1:0];
                    n_res_obj    = best_obj_w[OBJ_PORT_W-1:0];
                    n_res_rank   = best_rank_w[RANK_PORT_W-1:0];
                    if (r_kind == KIND_POP) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = r_best_idx;
                        ram_wr_data = {1'b0, r_best_rank, r_best_obj};
                    end
                end else begin
                    n_res_status = STAT_EMPTY;
                    n_res_id     = '0;
                    n_res_obj    = '0;
                    n_res_rank   = '0;
                end
                n_res_live = 1'b0;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_id     = r_res_id;
                    n_out_obj    = r_res_obj;
                    n_out_rank   = r_res_rank;
                    n_out_live   = r_res_live;
                end
            end
            default: begin
                n_out_valid = r_out_valid && i_out_stall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_id   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_id   <= n_next_id;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_id         <= n_id;
        r_obj        <= n_obj;
        r_scan_idx   <= n_scan_idx;
        r_found      <= n_found;
        r_best_idx   <= n_best_idx;
        r_best_rank  <= n_best_rank;
        r_best_obj   <= n_best_obj;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_obj    <= n_res_obj;
        r_res_rank   <= n_res_rank;
        r_res_live   <= n_res_live;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_obj    <= n_out_obj;
        r_out_rank   <= n_out_rank;
        r_out_live   <= n_out_live;
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_result_id     = r_out_id;
    assign o_result_object = r_out_obj;
    assign o_result_rank   = r_out_rank;
    assign o_is_live       = r_out_live;

    // ram writes only where an entry is created, promoted or popped
    `ASSERT_HOLDS(a_wr_state, i_clk, i_rst_n,
        ram_wr_en |-> (r_state == S_ISSUE || r_state == S_LOOK || r_state == S_FINISH),
        "ram write outside a write state")
    // id counter never passes the capacity
    `ASSERT_NEVER(a_next_id_cap, i_clk, i_rst_n,
        32'(r_next_id) > 32'(CAPACITY),
        "next id beyond capacity")
    // scan stays inside the handed out ids
    `ASSERT_HOLDS(a_scan_range, i_clk, i_rst_n,
        (r_state == S_SCAN) |-> (scan_idx_w < next_id_w),
        "scan index beyond next id")
    // a finished result moves out as soon as the output register is free
    `ASSERT_HOLDS(a_done_move, i_clk, i_rst_n,
        (r_state == S_DONE && out_free) |=> (r_state == S_IDLE && r_out_valid),
        "result not moved to output")

endmodule

`default_nettype wire

// ===== sim/tb_indexed_priority_table_unit.sv =====
// testbench of the indexed priority table unit: every result checked against a predictor or a directed expectation
`default_nettype none

module tb_indexed_priority_table_unit;
    import ipt_pkg::*;

    localparam int DEPTH         = IPT_CAPACITY;
    localparam int QUIET_LIMIT   = 4000;        // pop on a full table plus long stalls
    localparam int SETTLE_CYCLES = DEPTH + 16;  // one full scan after the last result
    localparam int PHASE_ITEMS   = 440;
    localparam int REPORT_LINES  = 50;
    localparam logic [RANK_PORT_W-1:0] RANK_TOP = '1;

    // kind codes with no meaning, the block answers all zero
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [ID_W-1:0]        id;
        logic [OBJ_PORT_W-1:0]  obj;
        logic [RANK_PORT_W-1:0] rank;
        logic                   live;
    } t_table_result;

    typedef struct {
        logic [KIND_W-1:0]     kind;
        logic [ID_W-1:0]       id;
        logic [OBJ_PORT_W-1:0] obj;
        bit                    typed;
        t_table_result         want;
    } t_directed_row;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic [KIND_W-1:0]      i_kind         = '0;
    logic [ID_W-1:0]        i_entry_id     = '0;
    logic [OBJ_PORT_W-1:0]  i_object_value = '0;
    logic                   i_out_stall    = 1'b0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [STATUS_W-1:0]    o_status;
    logic [ID_W-1:0]        o_result_id;
    logic [OBJ_PORT_W-1:0]  o_result_object;
    logic [RANK_PORT_W-1:0] o_result_rank;
    logic                   o_is_live;

    // predicted table contents
    logic [RANK_PORT_W-1:0] rank_mem [DEPTH];
    logic [OBJ_PORT_W-1:0]  obj_mem  [DEPTH];
    bit                     live_mem [DEPTH];
    int unsigned            ids_given;

    t_table_result awaited_results [$];
    t_directed_row plan [$];

    int mismatches      = 0;
    int quiet_cycles    = 0;
    int sender_idle_pct = 0;
    int stall_pct       = 0;

    indexed_priority_table_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_entry_id      (i_entry_id),
        .i_object_value  (i_object_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_result_id     (o_result_id),
        .o_result_object (o_result_object),
        .o_result_rank   (o_result_rank),
        .o_is_live       (o_is_live)
    );

    always #2 i_clk = ~i_clk;

    // one item applied to the predicted table, giving its result
    task automatic apply_to_table(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                                  input logic [OBJ_PORT_W-1:0] obj,
                                  output t_table_result res);
        int best;
        bit known;
        res   = '0;
        known = id < ids_given;
        case (kind)
            KIND_ADD: begin
                if (ids_given >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    rank_mem[ids_given] = '0;
                    obj_mem[ids_given]  = obj;
                    live_mem[ids_given] = 1'b1;
                    res.status = STAT_OK;
                    res.id     = ids_given[ID_W-1:0];
                    ids_given++;
                end
            end
            KIND_PROMOTE: begin
                res.id = id;
                if (known && live_mem[id]) begin
                    if (rank_mem[id] != RANK_TOP) rank_mem[id]++;
                    res.status = STAT_OK;
                    res.obj    = obj_mem[id];
                    res.rank   = rank_mem[id];
                    res.live   = 1'b1;
                end else begin
                    res.status = STAT_DEAD;
                end
            end
            KIND_POP, KIND_PEEK: begin
                // highest rank wins, equal ranks go to the larger id
                best = -1;
                for (int i = 0; i < ids_given; i++) begin
                    if (live_mem[i] && (best < 0 || rank_mem[i] >= rank_mem[best])) best = i;
                end
                if (best < 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    res.status = STAT_OK;
                    res.id     = best[ID_W-1:0];
                    res.obj    = obj_mem[best];
                    res.rank   = rank_mem[best];
                    if (kind == KIND_POP) live_mem[best] = 1'b0;
                end
            end
            KIND_QUERY: begin
                res.id = id;
                if (known && live_mem[id]) begin
                    res.status = STAT_OK;
                    res.obj    = obj_mem[id];
                    res.rank   = rank_mem[id];
                    res.live   = 1'b1;
                end else begin
                    // a popped id still shows its object
                    res.status = STAT_DEAD;
                    if (known) res.obj = obj_mem[id];
                end
            end
            default: begin
            end
        endcase
    endtask

    // offers one item after a random gap and holds it until accepted
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                             input logic [OBJ_PORT_W-1:0] obj, input bit typed,
                             input t_table_result want, output t_table_result predicted);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= kind;
        i_entry_id     <= id;
        i_object_value <= obj;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        apply_to_table(kind, id, obj, predicted);
        awaited_results.insert(awaited_results.size(), typed ? want : predicted);
    endtask

    task automatic send_random();
        int roll;
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0] id;
        t_table_result scratch;
        roll = $urandom_range(99);
        if (roll < 16)      kind = KIND_ADD;
        else if (roll < 52) kind = KIND_PROMOTE;
        else if (roll < 70) kind = KIND_QUERY;
        else if (roll < 82) kind = KIND_PEEK;
        else if (roll < 94) kind = KIND_POP;
        else                kind = KIND_W'($urandom_range(KIND_SPARE_C, KIND_SPARE_A));
        id = ID_W'($urandom);
        // most promotes and queries aim at ids already handed out
        if (ids_given != 0 && $urandom_range(9) != 0) id = ID_W'($urandom_range(ids_given - 1));
        send_item(kind, id, $urandom, 1'b0, '0, scratch);
    endtask

    // sender stays quiet until every result is back
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    // one row of the directed table, appended to the plan
    task automatic plan_row(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                            input logic [OBJ_PORT_W-1:0] obj, input bit typed,
                            input logic [STATUS_W-1:0] st, input logic [ID_W-1:0] rid);
        t_directed_row r;
        r.kind        = kind;
        r.id          = id;
        r.obj         = obj;
        r.typed       = typed;
        r.want        = '0;
        r.want.status = st;
        r.want.id     = rid;
        plan.insert(plan.size(), r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= REPORT_LINES)
            $display("mismatch in %s at %0t: got %0h, want %0h", what, $time, got, want);
    endtask

    // receiver stall, independent of anything the block does
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // result checker, oldest expectation first
    always @(posedge i_clk) begin
        t_table_result want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with no item waiting", 64'(o_result_id), '0);
            end else begin
                want = awaited_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 64'(o_status), 64'(want.status));
                if (o_result_id !== want.id)
                    report_mismatch("result_id", 64'(o_result_id), 64'(want.id));
                if (o_result_object !== want.obj)
                    report_mismatch("result_object", 64'(o_result_object), 64'(want.obj));
                if (o_result_rank !== want.rank)
                    report_mismatch("result_rank", 64'(o_result_rank), 64'(want.rank));
                if (o_is_live !== want.live)
                    report_mismatch("is_live", 64'(o_is_live), 64'(want.live));
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        t_table_result last;
        for (int i = 0; i < DEPTH; i++) begin
            rank_mem[i] = '0;
            obj_mem[i]  = '0;
            live_mem[i] = 1'b0;
        end
        ids_given = 0;

        // empty table, unknown ids and spare kinds, then a small table
        plan_row(KIND_PEEK, 8'h00, 32'h0, 1'b1, STAT_EMPTY, 8'h00);
        plan_row(KIND_POP, 8'hff, 32'hffff_ffff, 1'b1, STAT_EMPTY, 8'h00);
        plan_row(KIND_PROMOTE, 8'h00, 32'h0, 1'b1, STAT_DEAD, 8'h00);
        plan_row(KIND_QUERY, 8'hff, 32'h0, 1'b1, STAT_DEAD, 8'hff);
        plan_row(KIND_SPARE_A, 8'hff, 32'hffff_ffff, 1'b1, STAT_OK, 8'h00);
        plan_row(KIND_SPARE_C, 8'h00, 32'h0, 1'b1, STAT_OK, 8'h00);
        plan_row(KIND_ADD, 8'hff, 32'h0, 1'b1, STAT_OK, 8'h00);
        plan_row(KIND_ADD, 8'h00, 32'hffff_ffff, 1'b1, STAT_OK, 8'h01);
        plan_row(KIND_ADD, 8'h5a, 32'h5a5a_a5a5, 1'b1, STAT_OK, 8'h02);
        plan_row(KIND_PROMOTE, 8'h01, 32'h0, 1'b0, STAT_OK, 8'h00);
        plan_row(KIND_PROMOTE, 8'h01, 32'h0, 1'b0, STAT_OK, 8'h00);
        plan_row(KIND_PROMOTE, 8'h02, 32'h0, 1'b0, STAT_OK, 8'h00);
        plan_row(KIND_PEEK, 8'h00, 32'h0, 1'b0, STAT_OK, 8'h00);
        // equal ranks: the larger id has to win
        plan_row(KIND_PROMOTE, 8'h02, 32'h0, 1'b0, STAT_OK, 8'h00);
        plan_row(KIND_PEEK, 8'h00, 32'h0, 1'b0, STAT_OK, 8'h00);
        plan_row(KIND_POP, 8'h00, 32'h0, 1'b0, STAT_OK, 8'h00);
        // popped id keeps its object but is dead
        plan_row(KIND_QUERY, 8'h02, 32'h0, 1'b0, STAT_OK, 8'h00);
        plan_row(KIND_PROMOTE, 8'h02, 32'h0, 1'b1, STAT_DEAD, 8'h02);
        plan_row(KIND_QUERY, 8'h00, 32'h0, 1'b0, STAT_OK, 8'h00);
        plan_row(KIND_QUERY, 8'h03, 32'h0, 1'b1, STAT_DEAD, 8'h03);
        plan_row(KIND_SPARE_B, 8'hff, 32'hffff_ffff, 1'b1, STAT_OK, 8'h00);
        plan_row(KIND_POP, 8'h00, 32'h0, 1'b0, STAT_OK, 8'h00);
        plan_row(KIND_POP, 8'h00, 32'h0, 1'b0, STAT_OK, 8'h00);
        plan_row(KIND_POP, 8'h00, 32'h0, 1'b1, STAT_EMPTY, 8'h00);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) send_item(plan[r].kind, plan[r].id, plan[r].obj, plan[r].typed,
                                    plan[r].want, last);

        // random traffic under each idling pattern, drained between phases
        for (int phase = 0; phase < 4; phase++) begin
            hold_until_drained();
            case (phase)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 57; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 57; end
                default: begin sender_idle_pct = 32; stall_pct = 32; end
            endcase
            repeat (PHASE_ITEMS) send_random();
        end

        // pop the full-then-thinned table down to empty
        do send_item(KIND_POP, ID_W'($urandom), $urandom, 1'b0, '0, last);
        while (last.status != STAT_EMPTY);
        send_random();

        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && awaited_results.size() == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
